// ===== sv/ilp_pkg.sv =====
// ----------------------------------------------------------------------------
// ilp_pkg
// Types and character codes of the INI line parser.
// ----------------------------------------------------------------------------
`default_nettype none
package ilp_pkg;
   localparam logic [7:0] CH_HASH = 8'h23;
   localparam logic [7:0] CH_SEMI = 8'h3B;
   localparam logic [7:0] CH_CR   = 8'h0D;
   localparam logic [7:0] CH_LBR  = 8'h5B;
   localparam logic [7:0] CH_RBR  = 8'h5D;
   localparam logic [7:0] CH_EQ   = 8'h3D;
   localparam logic [7:0] CH_LF   = 8'h0A;
   localparam logic [7:0] CH_TAB  = 8'h09;
   localparam logic [7:0] CH_SP   = 8'h20;

   localparam logic [1:0] KIND_SECTION = 2'd0;
   localparam logic [1:0] KIND_KEY     = 2'd1;
   localparam logic [1:0] KIND_VALUE   = 2'd2;

   typedef enum logic [3:0] {
      PH_LEAD, PH_SKIP, PH_SECTION, PH_KEY, PH_VALUE_LEAD, PH_VALUE
   } phase_type;

   typedef enum logic [2:0] {
      ST_RUN, ST_EMIT_SEC, ST_EMIT_KEY, ST_EMIT_VAL, ST_COPY
   } state_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_buffer;
   } req_type;

   typedef struct packed {
      logic [1:0]  string_kind;
      logic [63:0] chunk_data;
      logic [3:0]  chunk_count;
      logic        last_of_entry;
   } rsp_type;
endpackage
`default_nettype wire

// ===== sv/ilp_if.sv =====
// ----------------------------------------------------------------------------
// ilp_if
// Valid/ready channel carrying one payload.
// ----------------------------------------------------------------------------
`default_nettype none
interface ilp_if #(parameter type T = logic);
   logic valid;
   logic ready;
   T     payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== sv/ilp_ram.sv =====
// ----------------------------------------------------------------------------
// ilp_ram
// Single write port, single registered read port memory.
// ----------------------------------------------------------------------------
`default_nettype none
module ilp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

// ===== sv/ini_line_parser.sv =====
// ----------------------------------------------------------------------------
// ini_line_parser
// Streaming INI parser: one text byte per request, chunked strings out.
// ----------------------------------------------------------------------------
// channel | dir | payload                                         | handshake
// req     | in  | data_byte, end_of_buffer                        | valid/ready
// rsp     | out | string_kind, chunk_data, chunk_count, last_of_entry | valid/ready
//
// One cycle per byte while a line is being read, except while a closed header is copied.
// A closing key/value line holds requests while its strings are emitted: a registered
// read and a merge per character, then a last read and hand-over per chunk; a closed
// header holds them while its kept section characters are copied into the section
// memory.
// Reset clears all counts and the line phase; text memories are not cleared.
// Output stalls hold the emission in place.
// ----------------------------------------------------------------------------
`default_nettype none
module ini_line_parser
   import ilp_pkg::*;
#(
   parameter int SECTION_CAP = 32,
   parameter int KEY_CAP     = 32,
   parameter int VALUE_CAP   = 128
) (
   input wire logic clock,
   input wire logic reset,
   ilp_if.sink      req,
   ilp_if.source    rsp
);
   localparam int SW = $clog2(SECTION_CAP);
   localparam int KW = $clog2(KEY_CAP);
   localparam int VW = $clog2(VALUE_CAP);
   localparam int CW = (VW > SW ? (VW > KW ? VW : KW) : (SW > KW ? SW : KW)) + 1;

   state_type  state_ff, state_in;
   phase_type  phase_ff, phase_in;
   logic [SW:0] sec_tr_ff, sec_tr_in, pend_st_ff, pend_st_in, pend_tr_ff, pend_tr_in;
   logic [KW:0] key_st_ff, key_st_in, key_tr_ff, key_tr_in;
   logic [VW:0] val_st_ff, val_st_in, val_tr_ff, val_tr_in;
   logic        eob_ff, eob_in;

   // emission / copy walker
   logic [CW-1:0] pos_ff, pos_in;
   logic [3:0]    sub_ff, sub_in;
   logic          rdv_ff, rdv_in;
   logic [63:0]   acc_ff, acc_in;
   logic          out_v_ff, out_v_in;
   rsp_type       out_ff, out_in;

   logic [7:0] sec_rd, pend_rd, key_rd, val_rd;
   logic       sec_we, pend_we, key_we, val_we;
   logic [SW-1:0] sec_wa, pend_wa, sec_ra;
   logic [KW-1:0] key_wa;
   logic [VW-1:0] val_wa;
   logic [7:0] wd;
   logic [CW-1:0] rd_idx;

   logic [7:0] c;
   logic       acc_req, blank, trimc;
   assign c     = req.payload.data_byte;
   assign blank = (c == CH_SP) || (c == CH_TAB);
   assign trimc = blank || (c == CH_CR);
   assign req.ready = (state_ff == ST_RUN);
   assign acc_req   = req.valid && req.ready;
   assign wd = c;

   ilp_ram #(.WIDTH(8), .DEPTH(SECTION_CAP)) u_sec (
      .clock, .wr_en(sec_we), .wr_addr(sec_wa), .wr_data(pend_rd),
      .rd_addr(sec_ra), .rd_data(sec_rd));
   ilp_ram #(.WIDTH(8), .DEPTH(SECTION_CAP)) u_pend (
      .clock, .wr_en(pend_we), .wr_addr(pend_wa), .wr_data(wd),
      .rd_addr(rd_idx[SW-1:0]), .rd_data(pend_rd));
   ilp_ram #(.WIDTH(8), .DEPTH(KEY_CAP)) u_key (
      .clock, .wr_en(key_we), .wr_addr(key_wa), .wr_data(wd),
      .rd_addr(rd_idx[KW-1:0]), .rd_data(key_rd));
   ilp_ram #(.WIDTH(8), .DEPTH(VALUE_CAP)) u_val (
      .clock, .wr_en(val_we), .wr_addr(val_wa), .wr_data(wd),
      .rd_addr(rd_idx[VW-1:0]), .rd_data(val_rd));

   assign sec_ra = rd_idx[SW-1:0];
   // copy writes the byte read in the cycle before
   assign sec_wa = pos_ff[SW-1:0] - SW'(1);
   assign sec_we = (state_ff == ST_COPY) && rdv_ff;

   logic [CW-1:0] len;
   logic [7:0]    rbyte;
   always_comb begin
      unique case (state_ff)
         ST_EMIT_SEC: begin len = CW'(sec_tr_ff); rbyte = sec_rd; end
         ST_EMIT_KEY: begin len = CW'(key_tr_ff); rbyte = key_rd; end
         default:     begin len = CW'(val_tr_ff); rbyte = val_rd; end
      endcase
   end
   assign rd_idx = pos_ff + CW'(sub_ff[2:0]);

   logic close, kv, emitting, chunk_done, rsp_free;
   logic [CW-1:0] remain;
   assign remain   = len - pos_ff;
   assign emitting = (state_ff == ST_EMIT_SEC) || (state_ff == ST_EMIT_KEY) ||
                     (state_ff == ST_EMIT_VAL);
   assign rsp_free = !out_v_ff || rsp.ready;
   // chunk complete once all its bytes are accumulated
   assign chunk_done = (CW'(sub_ff) >= remain) || (sub_ff == 4'd8);

   // request path: phase and counters
   always_comb begin
      phase_in = phase_ff;
      pend_st_in = pend_st_ff; pend_tr_in = pend_tr_ff;
      key_st_in = key_st_ff; key_tr_in = key_tr_ff;
      val_st_in = val_st_ff; val_tr_in = val_tr_ff;
      pend_we = 1'b0; key_we = 1'b0; val_we = 1'b0;
      pend_wa = pend_st_ff[SW-1:0]; key_wa = key_st_ff[KW-1:0];
      val_wa = val_st_ff[VW-1:0];
      close = 1'b0; kv = 1'b0;
      if (acc_req) begin
         if (c != CH_LF) begin
            unique case (phase_ff)
               PH_LEAD: begin
                  if (blank) begin
                  end else if (c == CH_HASH || c == CH_SEMI || c == CH_CR) begin
                     phase_in = PH_SKIP;
                  end else if (c == CH_LBR) begin
                     pend_st_in = '0; pend_tr_in = '0; phase_in = PH_SECTION;
                  end else if (c == CH_EQ) begin
                     key_st_in = '0; key_tr_in = '0;
                     val_st_in = '0; val_tr_in = '0; phase_in = PH_VALUE_LEAD;
                  end else begin
                     key_wa = '0; key_we = 1'b1;
                     key_st_in = (KW+1)'(1); key_tr_in = (KW+1)'(1);
                     phase_in = PH_KEY;
                  end
               end
               PH_SECTION: begin
                  if (c == CH_RBR) begin
                     phase_in = PH_SKIP;
                  end else if (32'(pend_st_ff) + 1 < SECTION_CAP) begin
                     pend_we = 1'b1; pend_st_in = pend_st_ff + 1'b1;
                     if (!trimc) pend_tr_in = pend_st_ff + 1'b1;
                  end
               end
               PH_KEY: begin
                  if (c == CH_EQ) begin
                     val_st_in = '0; val_tr_in = '0; phase_in = PH_VALUE_LEAD;
                  end else if (32'(key_st_ff) + 1 < KEY_CAP) begin
                     key_we = 1'b1; key_st_in = key_st_ff + 1'b1;
                     if (!trimc) key_tr_in = key_st_ff + 1'b1;
                  end
               end
               PH_VALUE_LEAD, PH_VALUE: begin
                  if (!(phase_ff == PH_VALUE_LEAD && blank)) begin
                     phase_in = PH_VALUE;
                     if (32'(val_st_ff) + 1 < VALUE_CAP) begin
                        val_we = 1'b1; val_st_in = val_st_ff + 1'b1;
                        if (!trimc) val_tr_in = val_st_ff + 1'b1;
                     end
                  end
               end
               default: begin
               end
            endcase
         end
         if (c == CH_LF || req.payload.end_of_buffer) begin
            close = 1'b1;
            kv = (phase_in == PH_VALUE_LEAD) || (phase_in == PH_VALUE);
            phase_in = PH_LEAD;
         end
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_RUN: begin
            if (close && kv) state_in = ST_EMIT_SEC;
            else if (acc_req && c == CH_RBR && phase_ff == PH_SECTION && c != CH_LF)
               state_in = ST_COPY;
         end
         ST_COPY: if (rdv_ff && (CW'(pend_tr_ff) <= pos_ff)) state_in = ST_RUN;
         ST_EMIT_SEC, ST_EMIT_KEY, ST_EMIT_VAL: begin
            if (rdv_ff && chunk_done && rsp_free && (pos_ff + CW'(sub_ff) >= len))
               unique case (state_ff)
                  ST_EMIT_SEC: state_in = ST_EMIT_KEY;
                  ST_EMIT_KEY: state_in = ST_EMIT_VAL;
                  default:     state_in = ST_RUN;
               endcase
         end
         default: state_in = ST_RUN;
      endcase
   end

   // walker and output register
   always_comb begin
      pos_in = pos_ff; sub_in = sub_ff; rdv_in = rdv_ff; acc_in = acc_ff;
      out_v_in = out_v_ff && !rsp.ready; out_in = out_ff;
      sec_tr_in = sec_tr_ff; eob_in = eob_ff;
      unique case (state_ff)
         ST_RUN: begin
            pos_in = '0; sub_in = '0; rdv_in = 1'b0; acc_in = '0;
            if (close && kv) eob_in = req.payload.end_of_buffer;
            if (state_in == ST_COPY) sec_tr_in = pend_tr_ff;
            if (close && !kv && req.payload.end_of_buffer) sec_tr_in = '0;
         end
         ST_COPY: begin
            rdv_in = 1'b1;
            pos_in = pos_ff + 1'b1;
            if (state_in == ST_RUN) begin
               pos_in = '0; rdv_in = 1'b0;
            end
         end
         default: begin
            if (!rdv_ff) begin
               rdv_in = 1'b1;
            end else if (!chunk_done) begin
               acc_in = acc_ff | (64'(rbyte) << {sub_ff[2:0], 3'b000});
               sub_in = sub_ff + 1'b1;
               rdv_in = 1'b0;
            end else if (rsp_free) begin
               out_v_in = 1'b1;
               out_in.string_kind = (state_ff == ST_EMIT_SEC) ? KIND_SECTION :
                                    (state_ff == ST_EMIT_KEY) ? KIND_KEY : KIND_VALUE;
               out_in.chunk_data = acc_ff;
               out_in.chunk_count = sub_ff;
               out_in.last_of_entry = (state_ff == ST_EMIT_VAL) &&
                                      (pos_ff + CW'(sub_ff) >= len);
               acc_in = '0; sub_in = '0; rdv_in = 1'b0;
               pos_in = pos_ff + CW'(sub_ff);
               if (state_in != state_ff) begin
                  pos_in = '0;
                  if (state_ff == ST_EMIT_VAL && eob_ff) sec_tr_in = '0;
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_RUN; phase_ff <= PH_LEAD;
         sec_tr_ff <= '0; pend_st_ff <= '0; pend_tr_ff <= '0;
         key_st_ff <= '0; key_tr_ff <= '0; val_st_ff <= '0; val_tr_ff <= '0;
         out_v_ff <= 1'b0; rdv_ff <= 1'b0; pos_ff <= '0; sub_ff <= '0;
         eob_ff <= 1'b0;
      end else begin
         state_ff <= state_in; phase_ff <= phase_in;
         sec_tr_ff <= sec_tr_in; pend_st_ff <= pend_st_in; pend_tr_ff <= pend_tr_in;
         key_st_ff <= key_st_in; key_tr_ff <= key_tr_in;
         val_st_ff <= val_st_in; val_tr_ff <= val_tr_in;
         out_v_ff <= out_v_in; rdv_ff <= rdv_in; pos_ff <= pos_in; sub_ff <= sub_in;
         eob_ff <= eob_in;
      end
      acc_ff <= acc_in;
      out_ff <= out_in;
   end

   assign rsp.valid   = out_v_ff;
   assign rsp.payload = out_ff;

   a_no_req_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_RUN |-> !req.ready) else $error("request taken while busy");
   a_count: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> rsp.payload.chunk_count <= 4'd8) else $error("chunk too long");
   a_trim: assert property (@(posedge clock) disable iff (reset)
      val_tr_ff <= val_st_ff && key_tr_ff <= key_st_ff) else $error("trim past store");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid) else $error("response dropped");
endmodule
`default_nettype wire
